>>> sv/binary_delta_patch_apply_macros.svh
// Assertion macros shared by the checkers of the delta patch applier.
`ifndef BINARY_DELTA_PATCH_APPLY_MACROS_SVH
`define BINARY_DELTA_PATCH_APPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bdpa_pkg.sv
// Package of types and constants for the delta patch applier.
package bdpa_pkg;

  // Width of the old image position counter, which wraps at this width.
  localparam int POSITION_BITS = 32;
  // Width of the reported old address.
  localparam int ADDR_BITS     = 32;
  // Width of sizes, run lengths and field magnitudes.
  localparam int MAG_BITS      = 31;
  // Width of a position plus a run length.
  localparam int SUM_BITS      = MAG_BITS + 1;
  // Width in which positions and magnitudes are compared and negated.
  localparam int WIDE_BITS     = (POSITION_BITS > MAG_BITS) ? POSITION_BITS : MAG_BITS;
  // Width in which the position is sign-extended before the address is cut.
  localparam int ADDR_EXT_BITS = (POSITION_BITS > ADDR_BITS) ? POSITION_BITS : ADDR_BITS;

  // A control record is three fields of eight bytes.
  localparam int FIELD_BYTES   = 8;
  localparam int RECORD_BYTES  = 3 * FIELD_BYTES;
  localparam int CNT_BITS      = $clog2(RECORD_BYTES);
  localparam int BYTE_IDX_BITS = $clog2(FIELD_BYTES);
  localparam int FIELD_IDX_BITS = CNT_BITS - BYTE_IDX_BITS;

  // Field order within a control record.
  localparam logic [FIELD_IDX_BITS-1:0] FLD_DIFF  = FIELD_IDX_BITS'(0);
  localparam logic [FIELD_IDX_BITS-1:0] FLD_EXTRA = FIELD_IDX_BITS'(1);
  localparam logic [FIELD_IDX_BITS-1:0] FLD_SEEK  = FIELD_IDX_BITS'(2);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OLD_SIZE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEW_SIZE = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    PH_CTRL  = 2'd0,
    PH_DIFF  = 2'd1,
    PH_EXTRA = 2'd2,
    PH_ERROR = 2'd3
  } phase_t;

  // Architectural state of the applier. The field accumulator keeps the low
  // magnitude bits and a flag for any set bit above them.
  typedef struct packed {
    phase_t                    phase;
    logic [CNT_BITS-1:0]       cnt;
    logic [MAG_BITS-1:0]       acc_low;
    logic                      acc_ovf;
    logic [MAG_BITS-1:0]       diff_left;
    logic [MAG_BITS-1:0]       extra_left;
    logic [POSITION_BITS-1:0]  seek;
    logic [POSITION_BITS-1:0]  old_pos;
    logic [MAG_BITS-1:0]       new_pos;
  } state_t;

  // One result item.
  typedef struct packed {
    logic                 byte_valid;
    logic [7:0]           new_byte;
    logic [ADDR_BITS-1:0] old_address;
    logic                 done_res;
    logic                 error;
  } result_t;

endpackage

>>> sv/bdpa_step.sv
// Next-state and result logic for one patch byte.
module bdpa_step (
  input  bdpa_pkg::state_t                 cur,
  input  logic [7:0]                       patch_byte,
  input  logic [7:0]                       old_byte,
  input  logic [bdpa_pkg::MAG_BITS-1:0]    old_size,
  input  logic [bdpa_pkg::MAG_BITS-1:0]    new_size,
  output bdpa_pkg::state_t                 nxt,
  output bdpa_pkg::result_t                res
);

  logic [bdpa_pkg::MAG_BITS-1:0]       mag;
  logic                                ovf;
  logic                                neg;
  logic                                field_err;
  logic [bdpa_pkg::WIDE_BITS-1:0]      mag_wide;
  logic [bdpa_pkg::POSITION_BITS-1:0]  seek_new;
  logic [bdpa_pkg::MAG_BITS-1:0]       pos_inc;
  logic                                diff_over;
  logic                                extra_over_ctrl;
  logic                                extra_over_diff;
  logic                                old_in_range;
  logic [bdpa_pkg::MAG_BITS-1:0]       diff_dec;
  logic [bdpa_pkg::MAG_BITS-1:0]       extra_dec;
  logic signed [bdpa_pkg::ADDR_EXT_BITS-1:0] addr_ext;

  // Shared arithmetic for the phases.
  always_comb begin
    neg      = patch_byte[7];
    mag_wide = bdpa_pkg::WIDE_BITS'(mag);
    seek_new = bdpa_pkg::POSITION_BITS'(neg ? (-mag_wide) : mag_wide);
    pos_inc  = cur.new_pos + bdpa_pkg::MAG_BITS'(1);
    diff_dec = cur.diff_left - bdpa_pkg::MAG_BITS'(1);
    extra_dec = cur.extra_left - bdpa_pkg::MAG_BITS'(1);
    diff_over = (bdpa_pkg::SUM_BITS'(cur.new_pos) + bdpa_pkg::SUM_BITS'(cur.diff_left))
                > bdpa_pkg::SUM_BITS'(new_size);
    extra_over_ctrl = (bdpa_pkg::SUM_BITS'(cur.new_pos) + bdpa_pkg::SUM_BITS'(cur.extra_left))
                      > bdpa_pkg::SUM_BITS'(new_size);
    extra_over_diff = (bdpa_pkg::SUM_BITS'(pos_inc) + bdpa_pkg::SUM_BITS'(cur.extra_left))
                      > bdpa_pkg::SUM_BITS'(new_size);
    old_in_range = !cur.old_pos[bdpa_pkg::POSITION_BITS-1] &&
                   (bdpa_pkg::WIDE_BITS'(cur.old_pos) < bdpa_pkg::WIDE_BITS'(old_size));
  end

  // Fold the incoming control byte into the field accumulator.
  always_comb begin
    mag = cur.acc_low;
    ovf = cur.acc_ovf;
    case (cur.cnt[bdpa_pkg::BYTE_IDX_BITS-1:0])
      3'd0:    mag[7:0]   = patch_byte;
      3'd1:    mag[15:8]  = patch_byte;
      3'd2:    mag[23:16] = patch_byte;
      3'd3: begin
        mag[30:24] = patch_byte[6:0];
        ovf        = cur.acc_ovf | patch_byte[7];
      end
      3'd7:    ovf = cur.acc_ovf | (|patch_byte[6:0]);
      default: ovf = cur.acc_ovf | (|patch_byte);
    endcase
    field_err = ovf ||
                ((cur.cnt[bdpa_pkg::CNT_BITS-1:bdpa_pkg::BYTE_IDX_BITS] != bdpa_pkg::FLD_SEEK)
                 && neg && (mag != '0));
  end

  // Phase sequencing, the produced byte and the status seen after this byte.
  always_comb begin
    nxt            = cur;
    res.byte_valid = 1'b0;
    res.new_byte   = 8'd0;
    case (cur.phase)
      bdpa_pkg::PH_CTRL: begin
        // At a record boundary with the image complete, bytes are dropped.
        if (!(cur.cnt == '0 && cur.new_pos >= new_size)) begin
          nxt.acc_low = mag;
          nxt.acc_ovf = ovf;
          nxt.cnt = (cur.cnt == bdpa_pkg::CNT_BITS'(bdpa_pkg::RECORD_BYTES - 1)) ?
                    '0 : cur.cnt + bdpa_pkg::CNT_BITS'(1);
          if (&cur.cnt[bdpa_pkg::BYTE_IDX_BITS-1:0]) begin
            nxt.acc_low = '0;
            nxt.acc_ovf = 1'b0;
            if (field_err) begin
              nxt.cnt   = '0;
              nxt.phase = bdpa_pkg::PH_ERROR;
            end else begin
              case (cur.cnt[bdpa_pkg::CNT_BITS-1:bdpa_pkg::BYTE_IDX_BITS])
                bdpa_pkg::FLD_DIFF:  nxt.diff_left  = mag;
                bdpa_pkg::FLD_EXTRA: nxt.extra_left = mag;
                default: begin
                  // Seek field closes the record: check the runs and start.
                  nxt.seek = seek_new;
                  if (diff_over) begin
                    nxt.phase = bdpa_pkg::PH_ERROR;
                  end else if (cur.diff_left != '0) begin
                    nxt.phase = bdpa_pkg::PH_DIFF;
                  end else if (extra_over_ctrl) begin
                    nxt.phase = bdpa_pkg::PH_ERROR;
                  end else if (cur.extra_left != '0) begin
                    nxt.phase = bdpa_pkg::PH_EXTRA;
                  end else begin
                    nxt.old_pos = cur.old_pos + seek_new;
                  end
                end
              endcase
            end
          end
        end
      end
      bdpa_pkg::PH_DIFF: begin
        res.byte_valid = 1'b1;
        res.new_byte   = old_in_range ? (patch_byte + old_byte) : patch_byte;
        nxt.old_pos    = cur.old_pos + bdpa_pkg::POSITION_BITS'(1);
        nxt.new_pos    = pos_inc;
        nxt.diff_left  = diff_dec;
        // End of the diff run: check the extra run, then go on.
        if (diff_dec == '0) begin
          if (extra_over_diff) begin
            nxt.phase = bdpa_pkg::PH_ERROR;
          end else if (cur.extra_left != '0) begin
            nxt.phase = bdpa_pkg::PH_EXTRA;
          end else begin
            nxt.old_pos = cur.old_pos + bdpa_pkg::POSITION_BITS'(1) + cur.seek;
            nxt.phase   = bdpa_pkg::PH_CTRL;
          end
        end
      end
      bdpa_pkg::PH_EXTRA: begin
        res.byte_valid = 1'b1;
        res.new_byte   = patch_byte;
        nxt.new_pos    = pos_inc;
        nxt.extra_left = extra_dec;
        if (extra_dec == '0) begin
          nxt.old_pos = cur.old_pos + cur.seek;
          nxt.phase   = bdpa_pkg::PH_CTRL;
        end
      end
      default: nxt.phase = bdpa_pkg::PH_ERROR;
    endcase
    addr_ext        = bdpa_pkg::ADDR_EXT_BITS'($signed(nxt.old_pos));
    res.old_address = addr_ext[bdpa_pkg::ADDR_BITS-1:0];
    res.done_res    = (nxt.new_pos >= new_size);
    res.error       = (nxt.phase == bdpa_pkg::PH_ERROR);
  end

endmodule

>>> sv/bdpa_out_buf.sv
// Two-entry result buffer that parts the input side from the output side.
module bdpa_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bdpa_pkg::result_t din,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output bdpa_pkg::result_t dout
);

  logic [1:0]        count;
  logic [1:0]        count_next;
  logic              pop;
  bdpa_pkg::result_t head;
  bdpa_pkg::result_t tail;

  assign pop       = (count != 2'd0) && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign dout      = head;

  always_comb begin
    count_next = count + 2'(push) - 2'(pop);
  end

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Payload slots; the head always holds the oldest beat.
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      head <= tail;
    end else if (push && (count == 2'd0 || (pop && count == 2'd1))) begin
      head <= din;
    end
    if (push && count == 2'd1 && !pop) begin
      tail <= din;
    end
  end

endmodule

>>> sv/binary_delta_patch_apply.sv
// Top level of the delta patch applier: state, size registers and result buffer.
//
// The block takes one patch byte per cycle while in_stall is low and returns
// one result beat for each, queued in the result buffer behind older beats.
// Each byte's work is a single pass through the step logic into the state
// register, so a byte may be accepted in every cycle; a two-entry result
// buffer keeps input acceptance going while the output side stalls, and
// in_stall rises only when both entries hold beats. In the diff phase the
// byte on old_byte must be the old image byte at old_address of the previous
// result. Sizes must be written through the configuration port only while the
// block is idle, which the block does not enforce; cfg_ready is always high.
module binary_delta_patch_apply (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          patch_byte,
  input  logic [7:0]                          old_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                byte_valid,
  output logic [7:0]                          new_byte,
  output logic signed [bdpa_pkg::ADDR_BITS-1:0] old_address,
  output logic                                done_res,
  output logic                                error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bdpa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bdpa_pkg::MAG_BITS-1:0]       cfg_data
);

  bdpa_pkg::state_t                state;
  bdpa_pkg::state_t                state_next;
  bdpa_pkg::result_t               step_res;
  bdpa_pkg::result_t               buf_res;
  logic [bdpa_pkg::MAG_BITS-1:0]   old_size;
  logic [bdpa_pkg::MAG_BITS-1:0]   new_size;
  logic                            buf_full;
  logic                            in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_take   = in_valid && !buf_full;

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      old_size <= '0;
      new_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdpa_pkg::CFG_OLD_SIZE: old_size <= cfg_data;
        bdpa_pkg::CFG_NEW_SIZE: new_size <= cfg_data;
        default: ;
      endcase
    end
  end

  bdpa_step u_step (
    .cur        (state),
    .patch_byte (patch_byte),
    .old_byte   (old_byte),
    .old_size   (old_size),
    .new_size   (new_size),
    .nxt        (state_next),
    .res        (step_res)
  );

  // State advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: bdpa_pkg::PH_CTRL, default: '0};
    end else if (in_take) begin
      state <= state_next;
    end
  end

  bdpa_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_take),
    .din       (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (buf_res)
  );

  assign byte_valid  = buf_res.byte_valid;
  assign new_byte    = buf_res.new_byte;
  assign old_address = buf_res.old_address;
  assign done_res    = buf_res.done_res;
  assign error       = buf_res.error;

endmodule

>>> sv/bdpa_checker.sv
// Port-level checker for the delta patch applier and its bind.
`include "binary_delta_patch_apply_macros.svh"

module bdpa_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             byte_valid,
  input logic [7:0]                       new_byte,
  input logic [bdpa_pkg::ADDR_BITS-1:0]   old_address,
  input logic                             done_res,
  input logic                             error
);

  // After an accepted byte, a result beat is always valid on the next cycle.
  `BDPA_ASSERT_NEXT(a_accept_gives_beat, in_valid && !in_stall, out_valid, "accepted byte without result beat")

  // The input side is held off only while results are waiting.
  `BDPA_ASSERT_NOW(a_stall_needs_backlog, in_stall, out_valid, "input stalled with no result waiting")

  // A beat carrying no image byte carries a zero byte.
  `BDPA_ASSERT_NOW(a_idle_byte_zero, out_valid && !byte_valid, new_byte == 8'd0, "non-data beat with nonzero byte")

  // A stalled result beat holds its payload.
  `BDPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(new_byte) && $stable(old_address) && $stable(error) && $stable(done_res) && $stable(byte_valid), "stalled result beat changed")

endmodule

bind binary_delta_patch_apply bdpa_checker u_bdpa_checker (.*);
